// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the glob matcher.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/psgm_pkg.sv
// Package for the prefix/substring glob matcher: widths, register codes, lane helper.
// No dependencies.
package psgm_pkg;

    localparam int CFG_W   = 64;
    localparam int ADDR_W  = 6;
    localparam int LEN_W   = 4;
    localparam int POS_W   = 5;
    localparam int LANES   = 8;

    localparam logic [POS_W-1:0] POS_MAX = 5'd31;

    typedef enum logic [2:0] {
        REG_MATCH_ALL     = 3'd0,
        REG_PREFIX_TEXT   = 3'd1,
        REG_PREFIX_LEN    = 3'd2,
        REG_PREFIX_EXACT  = 3'd3,
        REG_MIDDLE_TEXT   = 3'd4,
        REG_MIDDLE_LEN    = 3'd5,
        REG_MIDDLE_AT_END = 3'd6
    } reg_idx_t;

    function automatic logic [7:0] get_lane(input logic [CFG_W-1:0] word,
                                            input logic [2:0] idx);
        return word[8*idx +: 8];
    endfunction

endpackage

// File: rtl/prefix_and_substring_glob_match.sv
// Beats enter the input register; a last beat's verdict goes to the result register.
// Throughput: one byte per cycle; a last byte waits only while the result register is full.
// The per-byte work is one pass of lane compares between the input and result registers.
// Reset (rst_n, async, active low) clears config, valid flags, per-value state; no sweep.
// Depends on psgm_pkg, psgm_middle_cmp and assert_macros.svh.
`include "assert_macros.svh"

module prefix_and_substring_glob_match
    import psgm_pkg::*;
#(
    parameter int PATTERN_BYTES = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    // input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] character
    input  logic              s_tlast,
    // result stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [0] matched, [7:1] zero
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [CFG_W-1:0]  pwdata,
    output logic [CFG_W-1:0]  prdata,
    output logic              pready
);

    localparam int WIN_W = PATTERN_BYTES * 8;
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(PATTERN_BYTES);

    // configuration registers
    logic             match_all_reg;
    logic [CFG_W-1:0] prefix_text_reg;
    logic [LEN_W-1:0] prefix_len_reg;
    logic             prefix_exact_reg;
    logic [CFG_W-1:0] middle_text_reg;
    logic [LEN_W-1:0] middle_len_reg;
    logic             middle_at_end_reg;

    // input stage
    logic             s1_valid_reg;
    logic [7:0]       s1_char_reg;
    logic             s1_last_reg;

    // per-value state
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             pgood_reg, pgood_next;
    logic [WIN_W-1:0] window_reg, window_next;
    logic             mseen_reg, mseen_next;

    // result register
    logic             out_valid_reg;
    logic             out_matched_reg, out_matched_next;

    logic             advance;
    logic             cfg_write;
    reg_idx_t         cfg_idx;
    logic [LEN_W-1:0] plen, mlen;
    logic [WIN_W+7:0] window_cat;
    logic [POS_W-1:0] count;
    logic [POS_W-1:0] need_len;
    logic             window_hit;
    logic             mid_hit;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = reg_idx_t'(paddr[5:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_all_reg     <= 1'b0;
            prefix_text_reg   <= '0;
            prefix_len_reg    <= '0;
            prefix_exact_reg  <= 1'b0;
            middle_text_reg   <= '0;
            middle_len_reg    <= '0;
            middle_at_end_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_MATCH_ALL:     match_all_reg     <= pwdata[0];
                REG_PREFIX_TEXT:   prefix_text_reg   <= pwdata;
                REG_PREFIX_LEN:    prefix_len_reg    <= pwdata[LEN_W-1:0];
                REG_PREFIX_EXACT:  prefix_exact_reg  <= pwdata[0];
                REG_MIDDLE_TEXT:   middle_text_reg   <= pwdata;
                REG_MIDDLE_LEN:    middle_len_reg    <= pwdata[LEN_W-1:0];
                REG_MIDDLE_AT_END: middle_at_end_reg <= pwdata[0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_MATCH_ALL:     prdata = CFG_W'(match_all_reg);
            REG_PREFIX_TEXT:   prdata = prefix_text_reg;
            REG_PREFIX_LEN:    prdata = CFG_W'(prefix_len_reg);
            REG_PREFIX_EXACT:  prdata = CFG_W'(prefix_exact_reg);
            REG_MIDDLE_TEXT:   prdata = middle_text_reg;
            REG_MIDDLE_LEN:    prdata = CFG_W'(middle_len_reg);
            REG_MIDDLE_AT_END: prdata = CFG_W'(middle_at_end_reg);
            default:           prdata = '0;
        endcase
    end

    // A byte without last never touches the result register, so it always moves on.
    assign advance  = s1_valid_reg && (!s1_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            s1_char_reg <= s_tdata;
            s1_last_reg <= s_tlast;
        end
    end

    assign plen = (prefix_len_reg > LEN_LIMIT) ? LEN_LIMIT : prefix_len_reg;
    assign mlen = (middle_len_reg > LEN_LIMIT) ? LEN_LIMIT : middle_len_reg;

    assign window_cat = {window_reg, s1_char_reg};
    assign count      = (pos_reg < POS_MAX) ? pos_reg + 1'b1 : POS_MAX;
    assign need_len   = POS_W'(plen) + POS_W'(mlen);

    psgm_middle_cmp #(
        .PATTERN_BYTES(PATTERN_BYTES)
    ) u_middle_cmp (
        .window      (window_cat[WIN_W-1:0]),
        .middle_text (middle_text_reg),
        .mlen        (mlen),
        .hit         (mid_hit)
    );

    // The middle only counts once it lies wholly past the prefix.
    assign window_hit = (mlen != '0) && (count >= need_len) && mid_hit;

    always_comb
    begin
        pgood_next = pgood_reg;
        if ((pos_reg < POS_W'(plen)) &&
            (s1_char_reg != get_lane(prefix_text_reg, pos_reg[2:0])))
        begin
            pgood_next = 1'b0;
        end

        out_matched_next = 1'b1;
        if (match_all_reg)
        begin
            out_matched_next = 1'b1;
        end
        else if (prefix_exact_reg)
        begin
            out_matched_next = (plen != '0) && pgood_next && (count == POS_W'(plen));
        end
        else
        begin
            if ((plen != '0) && !(pgood_next && (count >= POS_W'(plen))))
            begin
                out_matched_next = 1'b0;
            end
            if (mlen != '0)
            begin
                if (middle_at_end_reg)
                begin
                    if (!window_hit)
                    begin
                        out_matched_next = 1'b0;
                    end
                end
                else if (!(mseen_reg || window_hit))
                begin
                    out_matched_next = 1'b0;
                end
            end
        end

        // Drop per-value state once the verdict is out.
        if (s1_last_reg)
        begin
            pos_next    = '0;
            pgood_next  = 1'b1;
            window_next = '0;
            mseen_next  = 1'b0;
        end
        else
        begin
            pos_next    = count;
            window_next = window_cat[WIN_W-1:0];
            mseen_next  = mseen_reg || window_hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            pgood_reg  <= 1'b1;
            window_reg <= '0;
            mseen_reg  <= 1'b0;
        end
        else if (advance)
        begin
            pos_reg    <= pos_next;
            pgood_reg  <= pgood_next;
            window_reg <= window_next;
            mseen_reg  <= mseen_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && s1_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_last_reg)
        begin
            out_matched_reg <= out_matched_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_matched_reg};

    `ASSERT_NEXT(a_clear_after_last, advance && s1_last_reg, (pos_reg == '0) && pgood_reg && !mseen_reg, "per-value state not cleared after last beat")
    `ASSERT_NEXT(a_pos_saturates, advance && !s1_last_reg && (pos_reg == POS_MAX), pos_reg == POS_MAX, "byte position wrapped past its ceiling")
    `ASSERT_NEXT(a_match_all_passes, advance && s1_last_reg && match_all_reg, m_tvalid && m_tdata[0], "match-all verdict not delivered as a pass")
    `ASSERT_SAME(a_last_held_when_full, s1_valid_reg && s1_last_reg && out_valid_reg && !m_tready, !s_tready && !advance, "last beat advanced into a full result register")

endmodule

// File: rtl/psgm_middle_cmp.sv
// Middle-text comparator: does the newest mlen bytes of the window equal the middle?
// Depends on psgm_pkg.
module psgm_middle_cmp
    import psgm_pkg::*;
#(
    parameter int PATTERN_BYTES = 8
)
(
    input  logic [PATTERN_BYTES*8-1:0] window,      // newest byte in lane 0
    input  logic [CFG_W-1:0]           middle_text,
    input  logic [LEN_W-1:0]           mlen,        // already clamped
    output logic                       hit
);

    logic [PATTERN_BYTES:1] hit_vec;

    // One candidate per middle length; the oldest byte of the run meets middle lane 0.
    always_comb
    begin
        hit_vec = '0;
        for (int m = 1; m <= PATTERN_BYTES; m++)
        begin
            hit_vec[m] = 1'b1;
            for (int i = 0; i < m; i++)
            begin
                if (window[8*(m-1-i) +: 8] != get_lane(middle_text, 3'(i)))
                begin
                    hit_vec[m] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        hit = 1'b0;
        for (int m = 1; m <= PATTERN_BYTES; m++)
        begin
            if (mlen == LEN_W'(m))
            begin
                hit = hit_vec[m];
            end
        end
    end

endmodule
